### hw/rtl/sorted_priority_queue_defines.svh
// ----------------------------------------------------------------------------
// Sorted priority queue assertion macros
// Shared concurrent assertion forms for the queue checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// same-cycle implication, masked during reset
`define SPQ_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("spq assertion failed");

// next-cycle implication, masked during reset
`define SPQ_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("spq assertion failed");

// same-cycle implication, also checked during reset
`define SPQ_ASSERT_ALWAYS(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |-> (cons)) \
      else $error("spq assertion failed");

`endif

### hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Entry and control types, command and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam logic       CMD_INSERT   = 1'b0;
   localparam logic       CMD_TAKE     = 1'b1;

   localparam logic [1:0] STATUS_DONE  = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam int         DATA_W       = 32;
   localparam int         LIMIT_W      = 5;
   localparam int         OCC_W        = 5;
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] prio;
   } spq_entry_type;

   typedef struct packed {
      logic ins_en;
      logic take_en;
   } spq_ctl_type;

endpackage

### hw/rtl/spq_if.sv
// ----------------------------------------------------------------------------
// Sorted priority queue channels
// Valid/ready channels for requests, responses and the limit register.
// ----------------------------------------------------------------------------
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic signed [31:0] in_value;
   logic signed [31:0] in_priority;

   modport source (output valid, output command, output in_value, output in_priority,
                   input ready);
   modport sink   (input valid, input command, input in_value, input in_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_value;
   logic signed [31:0] out_priority;
   logic [1:0]         status;
   logic [4:0]         occupancy;

   modport source (output valid, output out_value, output out_priority, output status,
                   output occupancy, input ready);
   modport sink   (input valid, input out_value, input out_priority, input status,
                   input occupancy, output ready);
endinterface

interface spq_csr_if;
   logic       valid;
   logic       ready;
   logic [4:0] capacity_limit;

   modport source (output valid, output capacity_limit, input ready);
   modport sink   (input valid, input capacity_limit, output ready);
endinterface

### hw/rtl/spq_cell.sv
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one entry; shifts right on insert below it, left on take.
// ----------------------------------------------------------------------------
module spq_cell
   import spq_pkg::*;
(
   input  logic          clock,
   input  spq_ctl_type   ctl,
   input  logic          occupied,
   input  spq_entry_type new_entry,
   input  spq_entry_type left_entry,
   input  logic          left_lower,
   input  spq_entry_type right_entry,
   output spq_entry_type entry,
   output logic          lower
);

   spq_entry_type entry_ff;
   spq_entry_type entry_in;
   logic          write_en;

   // free cells count as lower so the new entry lands at the tail
   assign lower = !occupied || (entry_ff.prio < new_entry.prio);

   always_comb begin
      entry_in = entry_ff;
      write_en = 1'b0;
      if (ctl.take_en) begin
         entry_in = right_entry;
         write_en = 1'b1;
      end else if (ctl.ins_en && lower) begin
         entry_in = left_lower ? left_entry : new_entry;
         write_en = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule

### hw/rtl/sorted_priority_queue.sv
// ----------------------------------------------------------------------------
// Sorted priority queue
// Entries kept in descending priority order in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage:
//   req: command (insert or take), in_value, in_priority.
//   rsp: out_value, out_priority, status, occupancy; one item per request.
//   csr: capacity_limit write, always ready; write only while idle.
// Latency: the response is valid the cycle after the request is accepted.
// Throughput: one item per cycle while rsp is not stalled. Every cell
//   compares its priority with the incoming one and shifts in the same
//   cycle, so no pass over the row is needed.
// Insert goes behind all entries of equal or higher priority; an insert at
//   the limit (capped to DEPTH) is dropped with status full. A take returns
//   the head; from an empty queue it returns zeros with status empty.
// Reset: queue empty, limit 16. Entry storage is not cleared.
// Stall: the response register holds while rsp.ready is low; a new request
//   is taken only when the register is free or draining in that cycle.
// ----------------------------------------------------------------------------
module sorted_priority_queue
   import spq_pkg::*;
#(
   parameter int DEPTH = 16
)
(
   input  logic clock,
   input  logic reset,
   spq_req_if.sink   req,
   spq_rsp_if.source rsp,
   spq_csr_if.sink   csr
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [LIMIT_W-1:0] limit_ff;
   logic               rsp_valid_ff;
   spq_entry_type      rsp_entry_ff, rsp_entry_in;
   logic [1:0]         status_ff, status_in;
   logic [OCC_W-1:0]   occ_ff;

   logic               accept;
   logic               full;
   logic [CMP_W-1:0]   limit_eff;
   spq_ctl_type        ctl;
   spq_entry_type      new_entry;

   spq_entry_type      cell_entry [DEPTH];
   logic               cell_lower [DEPTH];

   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign limit_eff = (CMP_W'(limit_ff) > DEPTH_C) ? DEPTH_C : CMP_W'(limit_ff);
   assign full      = CMP_W'(count_ff) >= limit_eff;

   assign new_entry.val  = req.in_value;
   assign new_entry.prio = req.in_priority;

   always_comb begin
      ctl.ins_en   = accept && (req.command == CMD_INSERT) && !full;
      ctl.take_en  = accept && (req.command == CMD_TAKE) && (count_ff != '0);
      count_in     = count_ff;
      rsp_entry_in = '0;
      status_in    = STATUS_DONE;
      if (ctl.ins_en) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.take_en) begin
         count_in     = count_ff - 1'b1;
         rsp_entry_in = cell_entry[0];
      end else if (req.command == CMD_INSERT) begin
         status_in = STATUS_FULL;
      end else begin
         status_in = STATUS_EMPTY;
      end
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (count_ff > CNT_W'(i)),
         .new_entry   (new_entry),
         .left_entry  ((i == 0) ? new_entry : cell_entry[(i == 0) ? 0 : i - 1]),
         .left_lower  ((i == 0) ? 1'b0 : cell_lower[(i == 0) ? 0 : i - 1]),
         .right_entry (cell_entry[(i == DEPTH - 1) ? i : i + 1]),
         .entry       (cell_entry[i]),
         .lower       (cell_lower[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            limit_ff <= csr.capacity_limit;
         end
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_entry_ff <= rsp_entry_in;
         status_ff    <= status_in;
         occ_ff       <= OCC_W'(count_in);
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.out_value    = rsp_entry_ff.val;
   assign rsp.out_priority = rsp_entry_ff.prio;
   assign rsp.status       = status_ff;
   assign rsp.occupancy    = occ_ff;

endmodule

### hw/rtl/spq_checker.sv
// ----------------------------------------------------------------------------
// Sorted priority queue checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_priority_queue_defines.svh"

module spq_checker
   import spq_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_out_value,
   input logic signed [31:0] rsp_out_priority,
   input logic [1:0]         rsp_status,
   input logic [4:0]         rsp_occupancy
);

   logic rsp_stall;
   logic rsp_zero;
   logic rsp_empty;
   logic rsp_full;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign rsp_zero  = (rsp_out_value == 32'sd0) && (rsp_out_priority == 32'sd0);
   assign rsp_empty = rsp_valid && (rsp_status == STATUS_EMPTY);
   assign rsp_full  = rsp_valid && (rsp_status == STATUS_FULL);

   `SPQ_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_out_value) && $stable(rsp_status))
   `SPQ_ASSERT_NOW(a_stall_blocks_req, rsp_stall, !req_ready)
   `SPQ_ASSERT_NOW(a_empty_zero, rsp_empty, (rsp_occupancy == 5'd0) && rsp_zero)
   `SPQ_ASSERT_NOW(a_full_zero, rsp_full, rsp_zero)
   `SPQ_ASSERT_ALWAYS(a_reset_idle, $past(reset) && !reset, !rsp_valid)

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req.ready),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_value    (rsp.out_value),
   .rsp_out_priority (rsp.out_priority),
   .rsp_status       (rsp.status),
   .rsp_occupancy    (rsp.occupancy)
);

### verif/sorted_priority_queue_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted priority queue testbench
// Drives insert and take items with random gaps on both channels and checks
// every response against a queue model that keeps entries in priority order.
// Covers edge values, equal priorities, the capacity limit register across
// its range, and a long response stall that backs up the request side.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam int QUEUE_DEPTH    = 16;
   localparam int TIMEOUT_CYCLES = 200000;

   typedef struct packed {
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] prio;
      logic [1:0]               status;
      logic [OCC_W-1:0]         occ;
   } queue_reply_type;

   logic clock;
   logic reset;

   spq_req_if req_ch ();
   spq_rsp_if rsp_ch ();
   spq_csr_if csr_ch ();

   sorted_priority_queue #(.DEPTH(QUEUE_DEPTH)) u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   spq_entry_type        held_entries[$];
   logic [LIMIT_W-1:0]   held_limit = LIMIT_RESET;
   queue_reply_type      expected_replies[$];
   queue_reply_type      want_reply;
   int                   error_count = 0;
   int                   send_idle_pct = 29;
   int                   recv_idle_pct = 61;
   int                   long_stall_left = 0;
   int                   cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < TIMEOUT_CYCLES) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   // receiver: random ready, or held low for a counted stretch
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            long_stall_left--;
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   function automatic queue_reply_type predict_reply(input logic cmd,
                                                     input logic signed [DATA_W-1:0] value,
                                                     input logic signed [DATA_W-1:0] prio);
      queue_reply_type r;
      spq_entry_type   e;
      int              pos;
      int              lim;
      r = '0;
      lim = (held_limit > QUEUE_DEPTH) ? QUEUE_DEPTH : int'(held_limit);
      if (cmd == CMD_INSERT) begin
         if (held_entries.size() >= lim) begin
            r.status = STATUS_FULL;
         end else begin
            e.val = value;
            e.prio = prio;
            pos = held_entries.size();
            while (pos > 0 && held_entries[pos-1].prio < prio) pos--;
            held_entries.insert(pos, e);
         end
      end else if (held_entries.size() == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         e = held_entries.pop_front();
         r.val = e.val;
         r.prio = e.prio;
      end
      r.occ = OCC_W'(held_entries.size());
      return r;
   endfunction

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_replies.size() == 0) begin
               $display("%0t: unexpected item expected none, got %h %h %h %h", $time,
                        rsp_ch.out_value, rsp_ch.out_priority, rsp_ch.status,
                        rsp_ch.occupancy);
               error_count++;
            end else begin
               want_reply = expected_replies.pop_front();
               compare_field("out_value", want_reply.val, rsp_ch.out_value);
               compare_field("out_priority", want_reply.prio, rsp_ch.out_priority);
               compare_field("status", 32'(want_reply.status), 32'(rsp_ch.status));
               compare_field("occupancy", 32'(want_reply.occ), 32'(rsp_ch.occupancy));
            end
         end
         if (csr_ch.valid && csr_ch.ready) held_limit = csr_ch.capacity_limit;
         if (req_ch.valid && req_ch.ready)
            expected_replies.push_back(predict_reply(req_ch.command, req_ch.in_value,
                                                     req_ch.in_priority));
      end
   end

   // valid stays high across back-to-back items; one assignment per edge
   task automatic send_item(input logic cmd, input logic [31:0] value,
                            input logic [31:0] prio);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.command     <= cmd;
      req_ch.in_value    <= value;
      req_ch.in_priority <= prio;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_replies.size() != 0) @(negedge clock);
   endtask

   task automatic set_capacity_limit(input logic [LIMIT_W-1:0] limit);
      wait_drained();
      repeat (2) @(negedge clock);
      csr_ch.valid          <= 1'b1;
      csr_ch.capacity_limit <= limit;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   function automatic logic [31:0] pick_priority();
      case ($urandom_range(3))
         0, 1: return 32'($urandom_range(4)) - 32'd2;
         2: begin
            case ($urandom_range(3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   task automatic test_edge_entries();
      send_item(CMD_TAKE, 32'h7fff_ffff, 32'h8000_0000);
      send_item(CMD_INSERT, 32'h8000_0000, 32'h8000_0000);
      send_item(CMD_INSERT, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(CMD_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(CMD_INSERT, 32'hffff_ffff, 32'hffff_ffff);
      send_item(CMD_INSERT, 32'h0000_0001, 32'h0000_0000);
      send_item(CMD_INSERT, 32'h5555_5555, 32'h7fff_ffff);
      send_item(CMD_INSERT, 32'haaaa_aaaa, 32'haaaa_aaaa);
      repeat (8) send_item(CMD_TAKE, $urandom, $urandom);
   endtask

   task automatic test_capacity_limits();
      set_capacity_limit(5'd0);
      send_item(CMD_INSERT, $urandom, pick_priority());
      send_item(CMD_TAKE, $urandom, $urandom);
      set_capacity_limit(5'd1);
      repeat (2) send_item(CMD_INSERT, $urandom, pick_priority());
      repeat (2) send_item(CMD_TAKE, $urandom, $urandom);
      // above depth acts as full depth
      set_capacity_limit(5'd31);
      repeat (QUEUE_DEPTH + 1) send_item(CMD_INSERT, $urandom, pick_priority());
      // lowered below what is held
      set_capacity_limit(5'd3);
      send_item(CMD_INSERT, $urandom, pick_priority());
      repeat (QUEUE_DEPTH - 3) send_item(CMD_TAKE, $urandom, $urandom);
      send_item(CMD_INSERT, $urandom, pick_priority());
      send_item(CMD_TAKE, $urandom, $urandom);
      send_item(CMD_INSERT, $urandom, pick_priority());
      repeat (4) send_item(CMD_TAKE, $urandom, $urandom);
   endtask

   task automatic test_random_traffic(input int count, input int s_pct, input int r_pct,
                                      input logic [LIMIT_W-1:0] limit);
      int   run_left;
      logic filling;
      logic cmd;
      run_left = 0;
      filling  = 1'b1;
      set_capacity_limit(limit);
      send_idle_pct = s_pct;
      recv_idle_pct = r_pct;
      for (int i = 0; i < count; i++) begin
         if (run_left == 0) begin
            filling  = 1'($urandom_range(1));
            run_left = $urandom_range(24, 1);
         end
         run_left--;
         if ($urandom_range(99) < 10) cmd = 1'($urandom_range(1));
         else cmd = filling ? CMD_INSERT : CMD_TAKE;
         send_item(cmd, $urandom, pick_priority());
      end
   endtask

   task automatic test_output_stall();
      set_capacity_limit(5'd16);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      long_stall_left = 80;
      for (int i = 0; i < 24; i++)
         send_item((i % 3 == 2) ? CMD_TAKE : CMD_INSERT, $urandom, pick_priority());
      wait_drained();
   endtask

   initial begin
      reset                 = 1'b1;
      req_ch.valid          = 1'b0;
      req_ch.command        = CMD_INSERT;
      req_ch.in_value       = '0;
      req_ch.in_priority    = '0;
      csr_ch.valid          = 1'b0;
      csr_ch.capacity_limit = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_edge_entries();
      test_capacity_limits();
      test_random_traffic(190, 29, 61, 5'd16);
      test_random_traffic(190, 61, 29, 5'd6);
      test_random_traffic(190, 0, 0, 5'd31);
      test_output_stall();

      wait_drained();
      repeat (4) @(posedge clock);
      if (error_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/spq_pkg.sv
hw/rtl/spq_if.sv
hw/rtl/spq_cell.sv
hw/rtl/sorted_priority_queue.sv
hw/rtl/spq_checker.sv
verif/sorted_priority_queue_test.sv
